[rtl/core/sqvg_pkg.sv]
// Shared types, constants and helper functions for the sprite quad vertex generator.
package sqvg_pkg;

  localparam int MAX_SPRITES      = 1024;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int TAB_AW           = $clog2(SINE_TABLE_DEPTH);

  localparam int OFS_W = 27;
  localparam int PRD_W = 43;
  localparam int SUM_W = 44;
  localparam int ROT_W = 30;
  localparam int POS_W = 24;

  localparam logic [14:0] THR_RESET = 15'd10;
  localparam logic [9:0]  SLOT_LAST = 10'((MAX_SPRITES - 1) % 1024);
  localparam logic        SLOT_CAP  = (MAX_SPRITES <= 1024);

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic signed [23:0] dest_x;
    logic signed [23:0] dest_y;
    logic [22:0]        dest_w;
    logic [22:0]        dest_h;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic signed [15:0] angle;
    logic [15:0]        u_left;
    logic [15:0]        u_right;
    logic [15:0]        v_bottom;
    logic [15:0]        v_top;
    logic               last_in_batch;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [1:0]         corner;
    logic [11:0]        vertex_index;
    logic               last;
    logic               batch_end;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       tab;
    logic       ofs;
    logic       rot;
    logic       fin;
    logic [1:0] corner;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctl_stat_t;

  typedef logic signed [15:0] sin_tab_t [SINE_TABLE_DEPTH];

  function automatic longint rnd14(longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    return r;
  endfunction

  function automatic longint sine_q14(longint b);
    longint s;
    longint x2;
    longint t;
    longint y;
    s = (b >= 32768) ? b - 65536 : b;
    if (s > 16384) begin
      s = 32768 - s;
    end else if (s < -16384) begin
      s = -32768 - s;
    end
    x2 = rnd14(s * s);
    t  = 10512 - rnd14(x2 * 1160);
    t  = 25736 - rnd14(x2 * t);
    y  = rnd14(s * t);
    if (y > 16384) y = 16384;
    if (y < -16384) y = -16384;
    return y;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      tab[k] = 16'(sine_q14(((longint'(k) * 65536) / SINE_TABLE_DEPTH) % 65536));
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic [TAB_AW-1:0] tab_index(logic [15:0] a);
    logic [31:0] p;
    logic [15:0] idx;
    p   = 32'(a) * 32'(SINE_TABLE_DEPTH) + 32'd32768;
    idx = p[31:16];
    if (idx >= 16'(SINE_TABLE_DEPTH)) begin
      idx = '0;
    end
    return idx[TAB_AW-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(logic signed [ROT_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v > (ROT_W + 1)'(signed'(24'sh7FFFFF))) begin
      r = 24'sh7FFFFF;
    end else if (v < (ROT_W + 1)'(signed'(-25'sd8388608))) begin
      r = 24'sh800000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/sqvg_ctrl.sv]
// Sequencing state machine for the sprite quad vertex generator.
module sqvg_ctrl import sqvg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TAB  = 5'b00010,
    S_OFS  = 5'b00100,
    S_ROT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    cmd        = '0;
    cmd.corner = corner_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          corner_nxt = CORNER_TL;
          state_nxt  = S_TAB;
        end
      end
      S_TAB: begin
        cmd.tab   = 1'b1;
        state_nxt = S_OFS;
      end
      S_OFS: begin
        cmd.ofs   = 1'b1;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin = 1'b1;
          if (corner_r == CORNER_BL) begin
            state_nxt = S_IDLE;
          end else begin
            corner_nxt = corner_r + 2'd1;
            state_nxt  = S_OFS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= CORNER_TL;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule

[rtl/core/sqvg_datapath.sv]
// Arithmetic datapath and output register for the sprite quad vertex generator.
module sqvg_datapath import sqvg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  in_item_t                 item_r;
  logic [14:0]              thr_r;
  logic [9:0]               slot_r;
  logic                     rot_r;
  logic signed [15:0]       cos_r, sin_r;
  logic signed [OFS_W-1:0]  ox_r, oy_r;
  logic signed [PRD_W-1:0]  cx_r, sy_r, cy_r, sx_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic [16:0]              abs_ang;
  logic                     rot_nxt;
  logic [15:0]              ang_u, cos_ang;
  logic signed [16:0]       fx, fy, dfx, dfy;
  logic signed [40:0]       px_prod, py_prod;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [ROT_W-1:0]  rx, ry;
  logic signed [ROT_W:0]    wx, wy;
  logic                     ends;
  out_item_t                out_nxt;

  assign abs_ang = in_data.angle[15] ? 17'(-$signed({in_data.angle[15], in_data.angle}))
                                     : {1'b0, in_data.angle};
  assign rot_nxt = abs_ang > {2'b00, thr_r};
  assign ang_u   = item_r.angle;
  assign cos_ang = ang_u + 16'd16384;

  assign fx  = (cmd.corner == CORNER_TR || cmd.corner == CORNER_BR) ? 17'sd16384 : 17'sd0;
  assign fy  = (cmd.corner == CORNER_BR || cmd.corner == CORNER_BL) ? 17'sd16384 : 17'sd0;
  assign dfx = fx - 17'(item_r.pivot_x);
  assign dfy = fy - 17'(item_r.pivot_y);
  assign px_prod = 41'(dfx) * 41'($signed({1'b0, item_r.dest_w}));
  assign py_prod = 41'(dfy) * 41'($signed({1'b0, item_r.dest_h}));

  assign sum_x = SUM_W'(cx_r) + SUM_W'(sy_r) + SUM_W'(8192);
  assign sum_y = SUM_W'(cy_r) - SUM_W'(sx_r) + SUM_W'(8192);
  assign rx    = ROT_W'(sum_x >>> 14);
  assign ry    = ROT_W'(sum_y >>> 14);
  assign wx    = (ROT_W + 1)'(item_r.dest_x) + (ROT_W + 1)'(rx);
  assign wy    = (ROT_W + 1)'(item_r.dest_y) + (ROT_W + 1)'(ry);

  assign ends  = item_r.last_in_batch || (SLOT_CAP && slot_r == SLOT_LAST);

  always_comb begin
    out_nxt.pos_x        = sat_pos(wx);
    out_nxt.pos_y        = sat_pos(wy);
    out_nxt.tex_u        = (cmd.corner == CORNER_TL || cmd.corner == CORNER_BL) ?
                           item_r.u_left : item_r.u_right;
    out_nxt.tex_v        = (cmd.corner == CORNER_TL || cmd.corner == CORNER_TR) ?
                           item_r.v_top : item_r.v_bottom;
    out_nxt.corner       = cmd.corner;
    out_nxt.vertex_index = {slot_r, cmd.corner};
    out_nxt.last         = (cmd.corner == CORNER_BL);
    out_nxt.batch_end    = (cmd.corner == CORNER_BL) && ends;
  end

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
        if (cmd.corner == CORNER_BL) begin
          slot_r <= ends ? '0 : slot_r + 10'd1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      rot_r  <= rot_nxt;
    end
    if (cmd.tab) begin
      sin_r <= rot_r ? SIN_TAB[tab_index(ang_u)] : 16'sd0;
      cos_r <= rot_r ? SIN_TAB[tab_index(cos_ang)] : 16'sd16384;
    end
    if (cmd.ofs) begin
      ox_r <= OFS_W'((px_prod + 41'sd8192) >>> 14);
      oy_r <= OFS_W'((py_prod + 41'sd8192) >>> 14);
    end
    if (cmd.rot) begin
      cx_r <= PRD_W'(cos_r) * PRD_W'(ox_r);
      sy_r <= PRD_W'(sin_r) * PRD_W'(oy_r);
      cy_r <= PRD_W'(cos_r) * PRD_W'(oy_r);
      sx_r <= PRD_W'(sin_r) * PRD_W'(ox_r);
    end
    if (cmd.fin) begin
      out_r <= out_nxt;
    end
  end

endmodule

[rtl/core/sprite_quad_vertex_generator_core.sv]
// Top level of the sprite quad vertex generator: controller plus datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_data (in_item_t), one sprite
//   out      output     out_valid/out_stall out_data (out_item_t), one vertex
//   cfg      input      cfg_we             cfg_wdata, angle threshold
//
// A sprite is accepted, then goes through the sine table lookup, then for each
// corner in turn through the offset multiplier, the rotation multipliers and
// the final add and saturation.
// Reset is synchronous, clears the batch slot and sets the threshold to 10.
// A stalled output beat holds the controller in its final step until taken.
module sprite_quad_vertex_generator_core import sqvg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  sqvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sqvg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
